### rtl/efd_pkg.sv
// Shared constants and types for the escaped frame deframer.
`default_nettype none

package efd_pkg;

  // Largest payload a frame may carry before it is dropped.
  localparam int unsigned MAX_PAYLOAD = 1024;

  // The frame length counter must be able to hold MAX_PAYLOAD itself.
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  // Fixed widths of the word fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TYPE_W  = 7;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned EVENT_W = 2;

  // Stream codes.
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hF0;
  localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h7F;
  localparam logic [BYTE_W-1:0] TYPE_LOW   = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_HIGH  = 8'h7E;

  // A completed frame with fewer payload bytes than this is flagged short.
  localparam int unsigned SHORT_LIMIT = 4 + 1;

  // Result event codes.
  typedef enum logic [EVENT_W-1:0] {
    EV_BYTE     = 2'd0,
    EV_DONE     = 2'd1,
    EV_OVERSIZE = 2'd2,
    EV_ABORT    = 2'd3
  } efd_event_t;

  // One result word, with its valid flag, as handed from parser to output stage.
  typedef struct packed {
    logic               valid;
    efd_event_t         event_res;
    logic [BYTE_W-1:0]  byte_value;
    logic [TYPE_W-1:0]  packet_type;
    logic [COUNT_W-1:0] payload_count;
    logic               reconnected;
    logic               too_short;
  } efd_result_t;

endpackage

`default_nettype wire

### rtl/efd_if.sv
// Handshake interfaces for the stream input and the result output.
`default_nettype none

interface efd_in_if;
  logic                     valid;
  logic                     ready;
  logic [efd_pkg::BYTE_W-1:0] data_byte;
  logic                     reconnect;

  modport source (output valid, output data_byte, output reconnect, input ready);
  modport sink   (input valid, input data_byte, input reconnect, output ready);
endinterface

interface efd_out_if;
  logic                        valid;
  logic                        ready;
  logic [efd_pkg::EVENT_W-1:0] event_res;
  logic [efd_pkg::BYTE_W-1:0]  byte_value;
  logic [efd_pkg::TYPE_W-1:0]  packet_type;
  logic [efd_pkg::COUNT_W-1:0] payload_count;
  logic                        reconnected;
  logic                        too_short;

  modport source (output valid, output event_res, output byte_value, output packet_type,
                  output payload_count, output reconnected, output too_short,
                  input ready);
  modport sink   (input valid, input event_res, input byte_value, input packet_type,
                  input payload_count, input reconnected, input too_short,
                  output ready);
endinterface

`default_nettype wire

### rtl/efd_parser.sv
// Input register, frame parse state and the per-byte decode logic.
`default_nettype none

module efd_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  efd_in_if.sink             in_chan,
  input  wire logic          out_free,
  output efd_pkg::efd_result_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IDLE_ESC,
    ST_FRAME,
    ST_FRAME_ESC
  } parse_state_t;

  parse_state_t                  state_r, state_nxt, st_cur;
  logic                          pending_r, pending_nxt, pend_cur;
  logic [efd_pkg::TYPE_W-1:0]    type_r, type_nxt;
  logic [efd_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic                          in_valid_r;
  logic [efd_pkg::BYTE_W-1:0]    in_byte_r;
  logic                          in_rc_r;
  logic                          advance, in_ready;
  logic                          take;
  logic [efd_pkg::BYTE_W-1:0]    take_val;

  // The held word moves on whenever the output stage can take its result.
  assign advance       = in_valid_r & out_free;
  assign in_ready      = ~in_valid_r | out_free;
  assign in_chan.ready = in_ready;

  // Decode one byte against the current parse state.
  always_comb begin
    // A reconnect is applied before the byte is parsed.
    st_cur   = in_rc_r ? ST_IDLE : state_r;
    pend_cur = in_rc_r | pending_r;

    state_nxt   = st_cur;
    pending_nxt = pend_cur;
    type_nxt    = type_r;
    len_nxt     = len_r;
    take        = 1'b0;
    take_val    = in_byte_r;

    res.valid       = 1'b0;
    res.event_res   = efd_pkg::EV_BYTE;
    res.byte_value  = '0;
    res.reconnected = 1'b0;
    res.too_short   = 1'b0;

    case (st_cur)
      ST_IDLE: begin
        if (in_byte_r == efd_pkg::ESC_BYTE) begin
          state_nxt = ST_IDLE_ESC;
        end
      end
      ST_IDLE_ESC: begin
        if (in_byte_r >= efd_pkg::TYPE_LOW && in_byte_r <= efd_pkg::TYPE_HIGH) begin
          type_nxt  = in_byte_r[efd_pkg::TYPE_W-1:0];
          len_nxt   = '0;
          state_nxt = ST_FRAME;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRAME: begin
        if (in_byte_r == efd_pkg::ESC_BYTE) begin
          state_nxt = ST_FRAME_ESC;
        end else begin
          take = 1'b1;
        end
      end
      ST_FRAME_ESC: begin
        if (in_byte_r == efd_pkg::END_BYTE) begin
          res.valid       = 1'b1;
          res.event_res   = efd_pkg::EV_DONE;
          res.reconnected = pend_cur;
          res.too_short   = (len_r < efd_pkg::LEN_W'(efd_pkg::SHORT_LIMIT));
          pending_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
        end else if (in_byte_r == efd_pkg::STUFF_BYTE) begin
          state_nxt = ST_FRAME;
          take      = 1'b1;
          take_val  = efd_pkg::ESC_BYTE;
        end else begin
          res.valid     = 1'b1;
          res.event_res = efd_pkg::EV_ABORT;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A payload byte either grows the frame or drops it when already full.
    if (take) begin
      res.valid = 1'b1;
      if (len_r < efd_pkg::LEN_W'(efd_pkg::MAX_PAYLOAD)) begin
        len_nxt        = len_r + efd_pkg::LEN_W'(1);
        res.byte_value = take_val;
      end else begin
        res.event_res = efd_pkg::EV_OVERSIZE;
        state_nxt     = ST_IDLE;
      end
    end

    res.packet_type   = type_r;
    res.payload_count = efd_pkg::COUNT_W'(32'(len_nxt));
    res.valid         = res.valid & advance;
  end

  // Input register and parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= ST_IDLE;
      pending_r  <= 1'b1;
      type_r     <= '0;
      len_r      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_chan.valid;
        in_byte_r  <= in_chan.data_byte;
        in_rc_r    <= in_chan.reconnect;
      end
      if (advance) begin
        state_r   <= state_nxt;
        pending_r <= pending_nxt;
        type_r    <= type_nxt;
        len_r     <= len_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/efd_out_stage.sv
// Result register that drives the output channel.
`default_nettype none

module efd_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  efd_pkg::efd_result_t      res,
  output logic                      out_free,
  efd_out_if.source                 out_chan
);

  logic                 out_valid_r;
  efd_pkg::efd_result_t res_r;

  // The register can be loaded when empty or when its word leaves this cycle.
  assign out_free = ~out_valid_r | out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
      if (res.valid) begin
        res_r <= res;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.event_res     = res_r.event_res;
  assign out_chan.byte_value    = res_r.byte_value;
  assign out_chan.packet_type   = res_r.packet_type;
  assign out_chan.payload_count = res_r.payload_count;
  assign out_chan.reconnected   = res_r.reconnected;
  assign out_chan.too_short     = res_r.too_short;

endmodule

`default_nettype wire

### rtl/escaped_frame_deframer_core.sv
// Top level of the escaped frame deframer.
`default_nettype none

// Byte-stuffed frame deframer. Each stream word (one byte plus a reconnect
// flag) is taken into an input register, decoded against the frame state in
// one pass and its result, if any, is loaded into the output register. One
// word is accepted every clock cycle unless the input stalls; a result passes
// through the input register and then the output register before it is shown.
// Words that produce no result (escapes, frame headers, idle bytes) leave
// nothing on the output. Back-pressure on the output stalls the input only
// when the output register is full and not being emptied.
// Payload bytes are passed on as they arrive; no frame is buffered.

module escaped_frame_deframer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  efd_in_if.sink    in_chan,
  efd_out_if.source out_chan
);

  efd_pkg::efd_result_t res;
  logic                 out_free;

  efd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_free (out_free),
    .res      (res)
  );

  efd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### rtl/efd_checker.sv
// Port-level checks for the escaped frame deframer, bound to the top level.
`default_nettype none

module efd_port_checks (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [efd_pkg::EVENT_W-1:0] event_res,
  input wire logic [efd_pkg::BYTE_W-1:0]  byte_value,
  input wire logic [efd_pkg::TYPE_W-1:0]  packet_type,
  input wire logic [efd_pkg::COUNT_W-1:0] payload_count,
  input wire logic                        reconnected,
  input wire logic                        too_short
);

  // No result is shown in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result word holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(byte_value)
      && $stable(packet_type) && $stable(payload_count) && $stable(reconnected)
      && $stable(too_short))
    else $error("stalled result changed");

  // Only payload words carry a byte value.
  a_byte_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != efd_pkg::EV_BYTE |-> byte_value == '0)
    else $error("byte value on a non-payload event");

  // Frame flags appear only on frame completion.
  a_flags_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != efd_pkg::EV_DONE |-> !reconnected && !too_short)
    else $error("frame flags on a non-completion event");

  // A payload word always counts at least itself.
  a_payload_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == efd_pkg::EV_BYTE && packet_type != '0 |-> payload_count != '0)
    else $error("payload word with zero count");

endmodule

bind escaped_frame_deframer_core efd_port_checks u_efd_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .event_res     (out_chan.event_res),
  .byte_value    (out_chan.byte_value),
  .packet_type   (out_chan.packet_type),
  .payload_count (out_chan.payload_count),
  .reconnected   (out_chan.reconnected),
  .too_short     (out_chan.too_short)
);

`default_nettype wire
